@@ hdl/crg_pkg.sv @@
// ----------------------------------------------------------------------------
// crg_pkg
// Shared types, codes and constants for the curved ramp generator.
// ----------------------------------------------------------------------------
package crg_pkg;

    localparam int FRAME_BITS     = 24;
    localparam int VALUE_BITS     = 32;
    localparam int DIST_BITS      = 32;
    localparam int SHAPE_BITS     = 3;
    localparam int CMD_BITS       = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam int MUL_BITS  = 32;
    localparam int DIV_NUM_BITS = 48;
    localparam int DIV_DEN_BITS = 32;
    localparam int DIV_Q_BITS   = 17;
    localparam int SQRT_IN_BITS = 32;
    localparam int SQRT_OUT_BITS = 16;

    localparam logic [31:0] LOG_DEN  = 32'd436353;
    localparam logic [31:0] SIN_C1   = 32'd1686629713;
    localparam logic [31:0] SIN_C3   = 32'd693598668;
    localparam logic [31:0] SIN_C5   = 32'd85569306;
    localparam logic [31:0] SIN_C7   = 32'd5026995;
    localparam logic [31:0] SIN_C9   = 32'd172272;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    typedef enum logic [2:0] {
        CMD_STEP       = 3'd0,
        CMD_JUMP_FWD   = 3'd1,
        CMD_JUMP_BACK  = 3'd2,
        CMD_SET_FRAME  = 3'd3,
        CMD_RESTART    = 3'd4,
        CMD_INDEX_QRY  = 3'd5,
        CMD_DIST_QRY   = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        SHAPE_LINEAR  = 3'd0,
        SHAPE_SQUARED = 3'd1,
        SHAPE_SINE    = 3'd2,
        SHAPE_SQRT    = 3'd3,
        SHAPE_LOG     = 3'd4
    } shape_t;

    typedef enum logic [2:0] {
        REG_START    = 3'd0,
        REG_END      = 3'd1,
        REG_FRAMES   = 3'd2,
        REG_DISTANCE = 3'd3,
        REG_SHAPE    = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_FRAC,
        ST_SQUARE,
        ST_SIN_T2,
        ST_SIN_POLY,
        ST_SIN_OUT,
        ST_SQRT,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_DIV,
        ST_SCALE,
        ST_DONE
    } state_t;

    function automatic logic [31:0] sin_coef(input logic [1:0] k);
        logic [31:0] c;
        case (k)
            2'd0:    c = SIN_C7;
            2'd1:    c = SIN_C5;
            2'd2:    c = SIN_C3;
            default: c = SIN_C1;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/crg_mul.sv @@
// ----------------------------------------------------------------------------
// crg_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module crg_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [crg_pkg::MUL_BITS-1:0]       a,
    input  logic [crg_pkg::MUL_BITS-1:0]       b,
    output logic                               done,
    output logic [2*crg_pkg::MUL_BITS-1:0]     product
);

    localparam int CNT_BITS = $clog2(crg_pkg::MUL_BITS);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_BITS-1:0]            cnt_reg;
    logic [crg_pkg::MUL_BITS-1:0]   a_reg;
    logic [crg_pkg::MUL_BITS-1:0]   hi_reg;
    logic [crg_pkg::MUL_BITS-1:0]   lo_reg;
    logic [crg_pkg::MUL_BITS:0]     sum;
    logic                           last;

    assign last = (cnt_reg == CNT_BITS'(crg_pkg::MUL_BITS - 1));
    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[crg_pkg::MUL_BITS:1];
            lo_reg <= {sum[0], lo_reg[crg_pkg::MUL_BITS-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

@@ hdl/crg_div.sv @@
// ----------------------------------------------------------------------------
// crg_div
// Restoring divider, one quotient bit per cycle; the quotient must fit
// DIV_Q_BITS bits.
// ----------------------------------------------------------------------------
module crg_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [crg_pkg::DIV_NUM_BITS-1:0]    num,
    input  logic [crg_pkg::DIV_DEN_BITS-1:0]    den,
    output logic                                done,
    output logic [crg_pkg::DIV_Q_BITS-1:0]      quotient
);

    localparam int QB       = crg_pkg::DIV_Q_BITS;
    localparam int DB       = crg_pkg::DIV_DEN_BITS;
    localparam int NB       = crg_pkg::DIV_NUM_BITS;
    localparam int CNT_BITS = $clog2(QB);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DB-1:0]       den_reg;
    logic [DB-1:0]       rem_reg;
    logic [QB-1:0]       bits_reg;
    logic [QB-1:0]       q_reg;
    logic [DB:0]         shifted;
    logic                fits;
    logic [DB:0]         diff;
    logic                last;

    assign last    = (cnt_reg == CNT_BITS'(QB - 1));
    assign shifted = {rem_reg, bits_reg[QB-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= DB'(num[NB-1:QB]);
            bits_reg <= num[QB-1:0];
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DB-1:0] : shifted[DB-1:0];
            bits_reg <= {bits_reg[QB-2:0], 1'b0};
            q_reg    <= {q_reg[QB-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ hdl/crg_sqrt.sv @@
// ----------------------------------------------------------------------------
// crg_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module crg_sqrt (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [crg_pkg::SQRT_IN_BITS-1:0]    radicand,
    output logic                                done,
    output logic [crg_pkg::SQRT_OUT_BITS-1:0]   root
);

    localparam int IB       = crg_pkg::SQRT_IN_BITS;
    localparam int OB       = crg_pkg::SQRT_OUT_BITS;
    localparam int RB       = OB + 2;
    localparam int CNT_BITS = $clog2(OB);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [IB-1:0]       bits_reg;
    logic [RB-1:0]       rem_reg;
    logic [OB-1:0]       root_reg;
    logic [RB+1:0]       shifted;
    logic [RB+1:0]       trial;
    logic                fits;
    logic [RB+1:0]       diff;
    logic                last;

    assign last    = (cnt_reg == CNT_BITS'(OB - 1));
    assign shifted = {rem_reg, bits_reg[IB-1:IB-2]};
    assign trial   = (RB+2)'({root_reg, 2'b01});
    assign fits    = (shifted >= trial);
    assign diff    = shifted - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bits_reg <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            bits_reg <= {bits_reg[IB-3:0], 2'b00};
            rem_reg  <= fits ? diff[RB-1:0] : shifted[RB-1:0];
            root_reg <= {root_reg[OB-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hdl/curved_ramp_generator_core.sv @@
// ----------------------------------------------------------------------------
// curved_ramp_generator_core
// Ramp from start to end value over a frame count, shaped by a selectable
// curve, with step, jump, set, restart and position queries.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid, in_stall, cmd, frame_amount,| word in
//          | distance                              |
//  out     | out_valid, out_stall, value, finished,| word out
//          | frame                                 |
//  cfg     | cfg_write, cfg_index, cfg_data        | register write
//
//  Words that resolve to a fixed value go from idle straight to done. A
//  curve word runs a divide, the shape, then a bit-serial scale multiply
//  on the multiplier that the squared, sine and log shapes share. One
//  word is in work at a time; the next is taken while a finished result
//  waits at the output.
//  Reset clears the configuration and the frame counter. No reset sweep.
// ----------------------------------------------------------------------------
module curved_ramp_generator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [crg_pkg::CMD_BITS-1:0]          cmd,
    input  logic [crg_pkg::FRAME_BITS-1:0]        frame_amount,
    input  logic [crg_pkg::DIST_BITS-1:0]         distance,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [crg_pkg::VALUE_BITS-1:0] value,
    output logic                                  finished,
    output logic [crg_pkg::FRAME_BITS-1:0]        frame,
    input  logic                                  cfg_write,
    input  logic [crg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [crg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int FB = crg_pkg::FRAME_BITS;
    localparam int VB = crg_pkg::VALUE_BITS;

    crg_pkg::state_t state_reg, state_next;
    logic            go_reg, go_next;

    logic signed [VB-1:0]          start_reg;
    logic signed [VB-1:0]          end_reg;
    logic [FB-1:0]                 tf_reg;
    logic [crg_pkg::DIST_BITS-1:0] td_reg;
    logic [crg_pkg::SHAPE_BITS-1:0] shape_reg;
    logic [FB-1:0]                 fc_reg, fc_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [VB-1:0] value_reg, value_next;
    logic                 finished_reg, finished_next;
    logic [FB-1:0]        frame_reg, frame_next;

    logic [VB-1:0]        res_reg, res_next;
    logic [15:0]          frac_reg, frac_next;
    logic signed [17:0]   w_reg, w_next;
    logic [30:0]          t_reg, t_next;
    logic [31:0]          t2_reg, t2_next;
    logic [31:0]          acc_reg, acc_next;
    logic [1:0]           k_reg, k_next;
    logic [22:0]          ym_reg, ym_next;
    logic [36:0]          m_reg, m_next;
    logic [2:0]           n_reg, n_next;
    logic [15:0]          lfrac_reg, lfrac_next;
    logic [3:0]           lcnt_reg, lcnt_next;
    logic [crg_pkg::DIV_NUM_BITS-1:0] num_reg, num_next;
    logic [crg_pkg::DIV_DEN_BITS-1:0] den_reg, den_next;

    logic                              mul_start, mul_done;
    logic                              div_start, div_done;
    logic                              sqrt_start, sqrt_done;
    logic [crg_pkg::MUL_BITS-1:0]      mul_a, mul_b;
    logic [2*crg_pkg::MUL_BITS-1:0]    mul_p;
    logic [crg_pkg::DIV_Q_BITS-1:0]    div_q;
    logic [crg_pkg::SQRT_OUT_BITS-1:0] sqrt_root;

    logic                in_acc;
    logic                flat;
    logic                out_free;
    logic [FB:0]         fwd_sum;
    logic [FB-1:0]       nf;
    logic                direct;
    logic [VB-1:0]       direct_val;
    logic [crg_pkg::DIV_NUM_BITS-1:0] c_num;
    logic [crg_pkg::DIV_DEN_BITS-1:0] c_den;

    logic [15:0]         f;
    logic [14:0]         rfold;
    logic [22:0]         y;
    logic signed [VB:0]  diff;
    logic [VB-1:0]       mag;
    logic [16:0]         wm;
    logic                neg;
    logic [33:0]         sq_m;
    logic [15:0]         lfrac_new;
    logic [16:0]         sin_res;
    logic [16:0]         sin_clamped;
    logic signed [VB+1:0] scaled;
    logic [VB-1:0]       sat_val;
    logic                unit_next;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != crg_pkg::ST_IDLE);
    assign flat     = (start_reg == end_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            tf_reg    <= '0;
            td_reg    <= '0;
            shape_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (crg_pkg::cfg_reg_t'(cfg_index))
                crg_pkg::REG_START:    start_reg <= cfg_data;
                crg_pkg::REG_END:      end_reg   <= cfg_data;
                crg_pkg::REG_FRAMES:   tf_reg    <= cfg_data[FB-1:0];
                crg_pkg::REG_DISTANCE: td_reg    <= cfg_data;
                crg_pkg::REG_SHAPE:    shape_reg <= cfg_data[crg_pkg::SHAPE_BITS-1:0];
                default:               ;
            endcase
        end
    end

    // command decode
    assign fwd_sum = {1'b0, fc_reg} + {1'b0, frame_amount};

    always_comb
    begin
        nf         = fc_reg;
        direct     = 1'b1;
        direct_val = end_reg;
        c_num      = {8'b0, fc_reg, 16'b0};
        c_den      = {8'b0, tf_reg};
        case (crg_pkg::cmd_t'(cmd))
            crg_pkg::CMD_STEP:
            begin
                if (!(tf_reg == '0 || fc_reg >= tf_reg || flat))
                begin
                    direct = 1'b0;
                    nf     = fc_reg + 1'b1;
                end
            end
            crg_pkg::CMD_INDEX_QRY:
            begin
                c_num = {8'b0, frame_amount, 16'b0};
                if (tf_reg == '0 || frame_amount >= tf_reg || flat)
                begin
                    direct_val = end_reg;
                end
                else if (frame_amount == '0)
                begin
                    direct_val = start_reg;
                end
                else
                begin
                    direct = 1'b0;
                end
            end
            crg_pkg::CMD_DIST_QRY:
            begin
                c_num = {distance, 16'b0};
                c_den = td_reg;
                if (distance == '0)
                begin
                    direct_val = start_reg;
                end
                else if (distance >= td_reg || flat)
                begin
                    direct_val = end_reg;
                end
                else
                begin
                    direct = 1'b0;
                end
            end
            default:
            begin
                case (crg_pkg::cmd_t'(cmd))
                    crg_pkg::CMD_JUMP_FWD:
                        nf = fwd_sum[FB] ? '1 : fwd_sum[FB-1:0];
                    crg_pkg::CMD_JUMP_BACK:
                        nf = (fc_reg > frame_amount) ? fc_reg - frame_amount : '0;
                    crg_pkg::CMD_SET_FRAME:
                        nf = frame_amount;
                    crg_pkg::CMD_RESTART:
                        nf = flat ? tf_reg : '0;
                    default:
                        nf = fc_reg;
                endcase
                c_num = {8'b0, nf, 16'b0};
                if (tf_reg == '0 || nf >= tf_reg)
                begin
                    direct_val = end_reg;
                end
                else if (nf == '0)
                begin
                    direct_val = start_reg;
                end
                else
                begin
                    direct = 1'b0;
                end
            end
        endcase
    end

    // datapath helpers
    assign f       = div_q[15:0];
    assign rfold   = f[14] ? (15'd16384 - {1'b0, f[13:0]}) : {1'b0, f[13:0]};
    assign y       = ({7'b0, f} << 6) + ({7'b0, f} << 5) + ({7'b0, f} << 2) + 23'd65536;
    assign diff    = {end_reg[VB-1], end_reg} - {start_reg[VB-1], start_reg};
    assign mag     = diff[VB] ? VB'(-diff) : diff[VB-1:0];
    assign wm      = w_reg[17] ? 17'(-w_reg) : w_reg[16:0];
    assign neg     = diff[VB] != w_reg[17];
    assign sq_m    = mul_p[63:30];
    assign lfrac_new = {lfrac_reg[14:0], sq_m[31]};
    assign sin_res = mul_p[60:44];
    assign sin_clamped = (sin_res > crg_pkg::ONE_Q16) ? crg_pkg::ONE_Q16 : sin_res;
    assign scaled  = neg ? ({{2{start_reg[VB-1]}}, start_reg} - {2'b0, mul_p[47:16]})
                         : ({{2{start_reg[VB-1]}}, start_reg} + {2'b0, mul_p[47:16]});

    always_comb
    begin
        if (scaled > $signed({3'b0, {(VB-1){1'b1}}}))
        begin
            sat_val = {1'b0, {(VB-1){1'b1}}};
        end
        else if (scaled < $signed({3'b111, {(VB-1){1'b0}}}))
        begin
            sat_val = {1'b1, {(VB-1){1'b0}}};
        end
        else
        begin
            sat_val = scaled[VB-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crg_pkg::ST_IDLE:
                if (in_acc)
                    state_next = direct ? crg_pkg::ST_DONE : crg_pkg::ST_DIV_FRAC;
            crg_pkg::ST_DIV_FRAC:
                if (div_done)
                begin
                    case (crg_pkg::shape_t'(shape_reg))
                        crg_pkg::SHAPE_SQUARED: state_next = crg_pkg::ST_SQUARE;
                        crg_pkg::SHAPE_SINE:    state_next = crg_pkg::ST_SIN_T2;
                        crg_pkg::SHAPE_SQRT:    state_next = crg_pkg::ST_SQRT;
                        crg_pkg::SHAPE_LOG:     state_next = crg_pkg::ST_LOG_NORM;
                        default:                state_next = crg_pkg::ST_SCALE;
                    endcase
                end
            crg_pkg::ST_SQUARE:
                if (mul_done)
                    state_next = crg_pkg::ST_SCALE;
            crg_pkg::ST_SIN_T2:
                if (mul_done)
                    state_next = crg_pkg::ST_SIN_POLY;
            crg_pkg::ST_SIN_POLY:
                if (mul_done && k_reg == 2'd3)
                    state_next = crg_pkg::ST_SIN_OUT;
            crg_pkg::ST_SIN_OUT:
                if (mul_done)
                    state_next = crg_pkg::ST_SCALE;
            crg_pkg::ST_SQRT:
                if (sqrt_done)
                    state_next = crg_pkg::ST_SCALE;
            crg_pkg::ST_LOG_NORM:
                if (ym_reg[22:17] == '0)
                    state_next = crg_pkg::ST_LOG_SQ;
            crg_pkg::ST_LOG_SQ:
                if (mul_done && lcnt_reg == 4'd15)
                    state_next = crg_pkg::ST_LOG_DIV;
            crg_pkg::ST_LOG_DIV:
                if (div_done)
                    state_next = crg_pkg::ST_SCALE;
            crg_pkg::ST_SCALE:
                if (mul_done)
                    state_next = crg_pkg::ST_DONE;
            crg_pkg::ST_DONE:
                if (out_free)
                    state_next = crg_pkg::ST_IDLE;
            default:
                state_next = crg_pkg::ST_IDLE;
        endcase
    end

    assign unit_next = (state_next == crg_pkg::ST_DIV_FRAC)
                    || (state_next == crg_pkg::ST_SQUARE)
                    || (state_next == crg_pkg::ST_SIN_T2) || (state_next == crg_pkg::ST_SIN_POLY)
                    || (state_next == crg_pkg::ST_SIN_OUT) || (state_next == crg_pkg::ST_SQRT)
                    || (state_next == crg_pkg::ST_LOG_SQ) || (state_next == crg_pkg::ST_LOG_DIV)
                    || (state_next == crg_pkg::ST_SCALE);

    // unit launch and datapath updates
    always_comb
    begin
        go_next = (unit_next && state_next != state_reg)
               || (state_reg == crg_pkg::ST_SIN_POLY && mul_done && k_reg != 2'd3)
               || (state_reg == crg_pkg::ST_LOG_SQ && mul_done && lcnt_reg != 4'd15);

        mul_start  = go_reg && ((state_reg == crg_pkg::ST_SQUARE)
                  || (state_reg == crg_pkg::ST_SIN_T2) || (state_reg == crg_pkg::ST_SIN_POLY)
                  || (state_reg == crg_pkg::ST_SIN_OUT) || (state_reg == crg_pkg::ST_LOG_SQ)
                  || (state_reg == crg_pkg::ST_SCALE));
        div_start  = go_reg && ((state_reg == crg_pkg::ST_DIV_FRAC)
                  || (state_reg == crg_pkg::ST_LOG_DIV));
        sqrt_start = go_reg && (state_reg == crg_pkg::ST_SQRT);

        case (state_reg)
            crg_pkg::ST_SQUARE:
            begin
                mul_a = {16'b0, frac_reg};
                mul_b = {16'b0, frac_reg};
            end
            crg_pkg::ST_SIN_T2:
            begin
                mul_a = {1'b0, t_reg};
                mul_b = {1'b0, t_reg};
            end
            crg_pkg::ST_SIN_POLY:
            begin
                mul_a = acc_reg;
                mul_b = t2_reg;
            end
            crg_pkg::ST_SIN_OUT:
            begin
                mul_a = acc_reg;
                mul_b = {1'b0, t_reg};
            end
            crg_pkg::ST_LOG_SQ:
            begin
                mul_a = m_reg[31:0];
                mul_b = m_reg[31:0];
            end
            default:
            begin
                mul_a = mag;
                mul_b = {15'b0, wm};
            end
        endcase
    end

    always_comb
    begin
        fc_next        = fc_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        finished_next  = finished_reg;
        frame_next     = frame_reg;
        res_next       = res_reg;
        frac_next      = frac_reg;
        w_next         = w_reg;
        t_next         = t_reg;
        t2_next        = t2_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        ym_next        = ym_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        lfrac_next     = lfrac_reg;
        lcnt_next      = lcnt_reg;
        num_next       = num_reg;
        den_next       = den_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            crg_pkg::ST_IDLE:
                if (in_acc)
                begin
                    fc_next  = nf;
                    res_next = direct_val;
                    num_next = c_num;
                    den_next = c_den;
                end
            crg_pkg::ST_DIV_FRAC:
                if (div_done)
                begin
                    frac_next = f;
                    w_next    = $signed({2'b0, f});
                    t_next    = {rfold, 16'b0};
                    ym_next   = y;
                    m_next    = {y, 14'b0};
                    n_next    = '0;
                end
            crg_pkg::ST_SQUARE:
                if (mul_done)
                    w_next = $signed({2'b0, mul_p[31:16]});
            crg_pkg::ST_SIN_T2:
                if (mul_done)
                begin
                    t2_next  = mul_p[61:30];
                    acc_next = crg_pkg::SIN_C9;
                    k_next   = '0;
                end
            crg_pkg::ST_SIN_POLY:
                if (mul_done)
                begin
                    acc_next = crg_pkg::sin_coef(k_reg) - mul_p[61:30];
                    k_next   = k_reg + 1'b1;
                end
            crg_pkg::ST_SIN_OUT:
                if (mul_done)
                    w_next = frac_reg[15] ? -$signed({1'b0, sin_clamped})
                                          : $signed({1'b0, sin_clamped});
            crg_pkg::ST_SQRT:
                if (sqrt_done)
                    w_next = $signed({2'b0, sqrt_root});
            crg_pkg::ST_LOG_NORM:
                if (ym_reg[22:17] != '0)
                begin
                    ym_next = ym_reg >> 1;
                    m_next  = m_reg >> 1;
                    n_next  = n_reg + 1'b1;
                end
                else
                begin
                    lcnt_next  = '0;
                    lfrac_next = '0;
                end
            crg_pkg::ST_LOG_SQ:
                if (mul_done)
                begin
                    lfrac_next = lfrac_new;
                    m_next     = sq_m[31] ? 37'(sq_m[31:1]) : 37'(sq_m[31:0]);
                    lcnt_next  = lcnt_reg + 1'b1;
                    num_next   = {13'b0, n_reg, lfrac_new, 16'b0};
                    den_next   = crg_pkg::LOG_DEN;
                end
            crg_pkg::ST_LOG_DIV:
                if (div_done)
                    w_next = $signed({1'b0, (div_q > crg_pkg::ONE_Q16) ? crg_pkg::ONE_Q16 : div_q});
            crg_pkg::ST_SCALE:
                if (mul_done)
                    res_next = sat_val;
            crg_pkg::ST_DONE:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_reg;
                    finished_next  = (fc_reg >= tf_reg);
                    frame_next     = fc_reg;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crg_pkg::ST_IDLE;
            go_reg        <= 1'b0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        finished_reg <= finished_next;
        frame_reg    <= frame_next;
        res_reg      <= res_next;
        frac_reg     <= frac_next;
        w_reg        <= w_next;
        t_reg        <= t_next;
        t2_reg       <= t2_next;
        acc_reg      <= acc_next;
        k_reg        <= k_next;
        ym_reg       <= ym_next;
        m_reg        <= m_next;
        n_reg        <= n_next;
        lfrac_reg    <= lfrac_next;
        lcnt_reg     <= lcnt_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
    end

    crg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    crg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    crg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({frac_reg, 16'b0}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign finished  = finished_reg;
    assign frame     = frame_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == crg_pkg::ST_DONE))
        else $error("result word raised outside the done state");

    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(fc_reg))
        else $error("frame counter moved without an accepted word");

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == crg_pkg::ST_SQUARE || state_reg == crg_pkg::ST_SIN_T2
            || state_reg == crg_pkg::ST_SIN_POLY || state_reg == crg_pkg::ST_SIN_OUT
            || state_reg == crg_pkg::ST_LOG_SQ || state_reg == crg_pkg::ST_SCALE))
        else $error("multiplier finished with no state waiting on it");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crg_pkg::ST_SCALE) |-> (w_reg <= 18'sd65536 && w_reg >= -18'sd65536))
        else $error("curve weight out of range");

endmodule

@@ verif/crg_checker.sv @@
// ----------------------------------------------------------------------------
// crg_checker
// Watches the word and register channels of the curved ramp generator,
// predicts every result word from its own copy of the frame counter and the
// registers, and compares value, finished and frame in order of arrival.
// ----------------------------------------------------------------------------
module crg_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic [crg_pkg::CMD_BITS-1:0]           cmd,
    input  logic [crg_pkg::FRAME_BITS-1:0]         frame_amount,
    input  logic [crg_pkg::DIST_BITS-1:0]          distance,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [crg_pkg::VALUE_BITS-1:0]  value,
    input  logic                                   finished,
    input  logic [crg_pkg::FRAME_BITS-1:0]         frame,
    input  logic                                   cfg_write,
    input  logic [crg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [crg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    output int                                     errors,
    output int                                     pending,
    output int                                     words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic               finished;
        logic [23:0]        frame;
    } ramp_word_t;

    localparam logic [63:0] FRAME_ALL_ONES = 64'hFF_FFFF;

    logic signed [63:0] ramp_start, ramp_end;
    logic [63:0]        ramp_frames, ramp_dist, ramp_counter;
    logic [2:0]         ramp_shape;
    ramp_word_t         ramp_queue[$];

    assign pending = ramp_queue.size();

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sine_wt(input logic [63:0] f);
        logic [1:0]  q;
        logic [63:0] r, t, t2, acc, res;
        q = f[15:14];
        r = f & 64'h3FFF;
        if (q[0]) r = 64'd16384 - r;
        t = r << 16;
        t2 = (t * t) >> 30;
        acc = 64'(crg_pkg::SIN_C9);
        acc = 64'(crg_pkg::SIN_C7) - ((acc * t2) >> 30);
        acc = 64'(crg_pkg::SIN_C5) - ((acc * t2) >> 30);
        acc = 64'(crg_pkg::SIN_C3) - ((acc * t2) >> 30);
        acc = 64'(crg_pkg::SIN_C1) - ((acc * t2) >> 30);
        res = ((acc * t) >> 30) >> 14;
        if (res > 65536) res = 65536;
        return q[1] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [63:0] log_wt(input logic [63:0] f);
        logic [63:0] y, m, frac, w;
        int h, n;
        y = 100 * f + 65536;
        h = 16;
        frac = 0;
        while (h < 40 && (y >> (h + 1)) != 0) h++;
        n = h - 16;
        m = (y << 14) >> n;
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac <<= 1;
            if (m >= (64'd1 << 31))
            begin
                m >>= 1;
                frac |= 1;
            end
        end
        w = (((64'(n) << 16) | frac) << 16) / 64'd436353;
        if (w > 65536) w = 65536;
        return $signed(w);
    endfunction

    function automatic logic signed [63:0] shaped_value(input logic [63:0] f);
        logic signed [63:0] w, diff, r;
        logic [63:0]        mag, wm;
        logic               neg;
        diff = ramp_end - ramp_start;
        case (ramp_shape)
            crg_pkg::SHAPE_SQUARED: w = $signed((f * f) >> 16);
            crg_pkg::SHAPE_SINE:    w = sine_wt(f);
            crg_pkg::SHAPE_SQRT:    w = $signed(root_floor(f << 16));
            crg_pkg::SHAPE_LOG:     w = log_wt(f);
            default:                w = $signed(f);
        endcase
        neg = (diff < 0) != (w < 0);
        mag = (diff < 0) ? -diff : diff;
        wm = (w < 0) ? -w : w;
        mag = (mag * wm) >> 16;
        r = neg ? ramp_start - $signed(mag) : ramp_start + $signed(mag);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function automatic logic signed [63:0] at_frame(input logic [63:0] pos);
        return shaped_value((pos << 16) / ramp_frames);
    endfunction

    function automatic ramp_word_t advance_ramp(input logic [2:0] c, input logic [63:0] amt,
                                                input logic [63:0] d);
        ramp_word_t         o;
        logic signed [63:0] v;
        logic               flat;
        flat = (ramp_start == ramp_end);
        case (c)
            crg_pkg::CMD_STEP:
                if (ramp_frames == 0 || ramp_counter >= ramp_frames || flat)
                    v = ramp_end;
                else
                begin
                    v = at_frame(ramp_counter);
                    ramp_counter = (ramp_counter + 1) & FRAME_ALL_ONES;
                end
            crg_pkg::CMD_INDEX_QRY:
                if (ramp_frames == 0 || amt >= ramp_frames || flat) v = ramp_end;
                else if (amt == 0) v = ramp_start;
                else v = at_frame(amt);
            crg_pkg::CMD_DIST_QRY:
                if (d == 0) v = ramp_start;
                else if (d >= ramp_dist || flat) v = ramp_end;
                else v = shaped_value((d << 16) / ramp_dist);
            default:
            begin
                if (c == crg_pkg::CMD_JUMP_FWD)
                begin
                    ramp_counter = ramp_counter + amt;
                    if (ramp_counter > FRAME_ALL_ONES) ramp_counter = FRAME_ALL_ONES;
                end
                else if (c == crg_pkg::CMD_JUMP_BACK)
                    ramp_counter = (ramp_counter > amt) ? ramp_counter - amt : 0;
                else if (c == crg_pkg::CMD_SET_FRAME)
                    ramp_counter = amt;
                else if (c == crg_pkg::CMD_RESTART)
                    ramp_counter = flat ? ramp_frames : 0;
                if (ramp_frames == 0 || ramp_counter >= ramp_frames) v = ramp_end;
                else if (ramp_counter == 0) v = ramp_start;
                else v = at_frame(ramp_counter);
            end
        endcase
        o.value = v[31:0];
        o.finished = ramp_counter >= ramp_frames;
        o.frame = ramp_counter[23:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch word %0d %s: got %h want %h", words_seen, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ramp_word_t want;
        if (!rst_n)
        begin
            ramp_start = 0;
            ramp_end = 0;
            ramp_frames = 0;
            ramp_dist = 0;
            ramp_shape = 0;
            ramp_counter = 0;
            ramp_queue.delete();
            errors = 0;
            words_seen = 0;
        end
        else
        begin
            if (cfg_write)
                case (cfg_index)
                    crg_pkg::REG_START:    ramp_start = $signed(cfg_data);
                    crg_pkg::REG_END:      ramp_end = $signed(cfg_data);
                    crg_pkg::REG_FRAMES:   ramp_frames = cfg_data[23:0];
                    crg_pkg::REG_DISTANCE: ramp_dist = cfg_data;
                    crg_pkg::REG_SHAPE:    ramp_shape = cfg_data[2:0];
                    default:               ;
                endcase
            if (in_valid && !in_stall)
                ramp_queue.push_back(advance_ramp(cmd, frame_amount, distance));
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (ramp_queue.size() == 0)
                begin
                    $display("unexpected result word %0d", words_seen);
                    errors++;
                end
                else
                begin
                    want = ramp_queue.pop_front();
                    if (value !== want.value) report_mismatch("value", value, want.value);
                    if (finished !== want.finished)
                        report_mismatch("finished", finished, want.finished);
                    if (frame !== want.frame) report_mismatch("frame", frame, want.frame);
                end
            end
        end
    end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the curved ramp generator through directed and random command words
// under several register settings, with bursty input and patterned output
// stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int WORD_TARGET = 1520;
    localparam logic [2:0] CMD_SPARE = 3'd7;
    localparam logic [2:0] SHAPE_SPARE = 3'd7;

    logic                                  clk, rst_n;
    logic                                  in_valid, in_stall, out_valid, out_stall;
    logic [crg_pkg::CMD_BITS-1:0]          cmd;
    logic [crg_pkg::FRAME_BITS-1:0]        frame_amount;
    logic [crg_pkg::DIST_BITS-1:0]         distance;
    logic signed [crg_pkg::VALUE_BITS-1:0] value;
    logic                                  finished;
    logic [crg_pkg::FRAME_BITS-1:0]        frame;
    logic                                  cfg_write;
    logic [crg_pkg::CFG_INDEX_BITS-1:0]    cfg_index;
    logic [crg_pkg::CFG_DATA_BITS-1:0]     cfg_data;
    int                                    errors, pending, words_seen;
    int                                    idle_cycles, words_sent, settings_run;

    curved_ramp_generator_core dut (.*);

    crg_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int phase;
        out_stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 64;
            if (phase < 16) out_stall <= 0;
            else if (phase < 32) out_stall <= ($urandom_range(0, 3) == 0);
            else out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    always @(posedge clk)
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
        else idle_cycles <= idle_cycles + 1;

    task automatic write_reg(input crg_pkg::cfg_reg_t idx, input logic [31:0] data);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 0;
    endtask

    task automatic drain;
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic send_word(input logic [2:0] c, input logic [23:0] amt, input logic [31:0] d);
        cmd <= c;
        frame_amount <= amt;
        distance <= d;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    task automatic gap;
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic setup(input logic [31:0] s, input logic [31:0] e, input logic [23:0] n,
                         input logic [31:0] d, input logic [2:0] sh);
        drain();
        write_reg(crg_pkg::REG_START, s);
        write_reg(crg_pkg::REG_END, e);
        write_reg(crg_pkg::REG_FRAMES, {8'd0, n});
        write_reg(crg_pkg::REG_DISTANCE, d);
        write_reg(crg_pkg::REG_SHAPE, {29'd0, sh});
        settings_run++;
    endtask

    task automatic random_burst(input int count, input logic [23:0] n);
        int burst;
        logic [2:0] c;
        logic [23:0] amt;
        logic [31:0] d;
        burst = $urandom_range(1, 8);
        for (int i = 0; i < count; i++)
        begin
            c = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : crg_pkg::CMD_STEP;
            case ($urandom_range(0, 3))
                0:       amt = 24'($urandom);
                1:       amt = 24'($urandom_range(0, 3));
                default: amt = (n == 0) ? 24'd0 : 24'($urandom_range(0, n));
            endcase
            d = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 65536 * 8);
            send_word(c, amt, d);
            if (--burst == 0)
            begin
                gap();
                burst = $urandom_range(1, 8);
            end
        end
        in_valid <= 0;
    endtask

    initial
    begin
        logic [23:0] n;
        rst_n = 0;
        in_valid = 0;
        cmd = 0;
        frame_amount = 0;
        distance = 0;
        cfg_write = 0;
        cfg_index = 0;
        cfg_data = 0;
        idle_cycles = 0;
        words_sent = 0;
        settings_run = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset state, then every command and edge case
        send_word(crg_pkg::CMD_STEP, 0, 0);
        setup(32'hFFF0_0000, 32'h7FFF_FFFF, 24'd8, 32'h0008_0000, crg_pkg::SHAPE_SINE);
        send_word(crg_pkg::CMD_STEP, 0, 0);
        send_word(crg_pkg::CMD_STEP, 0, 0);
        send_word(crg_pkg::CMD_JUMP_FWD, 24'hFF_FFFF, 0);
        send_word(crg_pkg::CMD_STEP, 0, 0);
        send_word(crg_pkg::CMD_JUMP_BACK, 24'hFF_FFFF, 0);
        send_word(crg_pkg::CMD_SET_FRAME, 24'd5, 0);
        send_word(crg_pkg::CMD_INDEX_QRY, 24'd0, 0);
        send_word(crg_pkg::CMD_INDEX_QRY, 24'd3, 0);
        send_word(crg_pkg::CMD_INDEX_QRY, 24'd8, 0);
        send_word(crg_pkg::CMD_DIST_QRY, 0, 32'd0);
        send_word(crg_pkg::CMD_DIST_QRY, 0, 32'h0006_0000);
        send_word(crg_pkg::CMD_DIST_QRY, 0, 32'hFFFF_FFFF);
        send_word(CMD_SPARE, 24'hAAAAAA, 32'h5555_5555);
        send_word(crg_pkg::CMD_RESTART, 0, 0);
        in_valid <= 0;
        setup(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, SHAPE_SPARE);
        send_word(crg_pkg::CMD_INDEX_QRY, 24'h7F_FFFF, 32'h8000_0000);
        send_word(crg_pkg::CMD_DIST_QRY, 0, 32'h8000_0000);
        send_word(crg_pkg::CMD_SET_FRAME, 24'hFF_FFFE, 0);
        send_word(crg_pkg::CMD_STEP, 0, 0);
        in_valid <= 0;
        setup(32'h0001_0000, 32'h0001_0000, 24'd4, 32'd0, crg_pkg::SHAPE_LOG);
        send_word(crg_pkg::CMD_RESTART, 0, 0);
        send_word(crg_pkg::CMD_DIST_QRY, 0, 32'd0);
        send_word(crg_pkg::CMD_DIST_QRY, 0, 32'd1);
        in_valid <= 0;

        // random settings, mostly short ramps
        while (words_sent < WORD_TARGET)
        begin
            n = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
            setup(($urandom_range(0, 4) == 0) ? 32'h0 : $urandom,
                  ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom, n,
                  ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom, 3'($urandom_range(0, 7)));
            random_burst(60, n);
        end
        drain();

        $display("sent %0d command words across %0d register settings, %0d results checked",
                 words_sent, settings_run, words_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/crg_pkg.sv
hdl/crg_mul.sv
hdl/crg_div.sv
hdl/crg_sqrt.sv
hdl/curved_ramp_generator_core.sv
verif/crg_checker.sv
verif/testbench.sv
